/* rtl/core/svge_pkg.sv */
// ----------------------------------------------------------------------------
// svge_pkg
// Shared types and codes for the state vector gate engine.
// ----------------------------------------------------------------------------
package svge_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_WRITE  = 3'd1,
		OP_READ   = 3'd2,
		OP_MATRIX = 3'd3,
		OP_GATE1  = 3'd4,
		OP_GATE2  = 3'd5,
		OP_RESETQ = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_BAD  = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	localparam int MAT_FRAC = 14;

	// command from sequencer to the complex multiply-accumulate unit
	typedef struct packed {
		logic clr;   // start new sum
		logic acc;   // accumulate product this cycle
	} mac_ctl_t;

endpackage

/* rtl/core/svge_ram.sv */
// ----------------------------------------------------------------------------
// svge_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module svge_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/core/svge_mac.sv */
// ----------------------------------------------------------------------------
// svge_mac
// Shared complex multiply-accumulate unit: one product term per cycle while acc is set.
// ----------------------------------------------------------------------------
module svge_mac #(
	parameter int AB = 16
) (
	input  logic                  clk,
	input  svge_pkg::mac_ctl_t    ctl,
	input  logic signed [15:0]    m_re,
	input  logic signed [16:0]    m_im,
	input  logic signed [AB-1:0]  a_re,
	input  logic signed [AB-1:0]  a_im,
	output logic signed [AB+20:0] s_re,
	output logic signed [AB+20:0] s_im
);
	import svge_pkg::*;
	logic signed [AB+17:0] p_rr, p_ii, p_ri, p_ir;
	logic signed [AB+20:0] re_q, im_q;

	assign p_rr = (AB+18)'(m_re * a_re);
	assign p_ii = (AB+18)'(m_im * a_im);
	assign p_ri = (AB+18)'(m_re * a_im);
	assign p_ir = (AB+18)'(m_im * a_re);

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			re_q <= '0;
			im_q <= '0;
		end else if (ctl.acc) begin
			re_q <= re_q + (AB+21)'(p_rr) - (AB+21)'(p_ii);
			im_q <= im_q + (AB+21)'(p_ri) + (AB+21)'(p_ir);
		end
	end
	assign s_re = re_q;
	assign s_im = im_q;
endmodule

/* rtl/core/state_vector_gate_engine_top.sv */
// ----------------------------------------------------------------------------
// state_vector_gate_engine_top
// State-vector gate engine: complex amplitude vector plus gate matrix store.
// ----------------------------------------------------------------------------
// Usage: raise start with opcode and operands while busy is low; the request
// is taken at that edge and busy rises. One result (read_re, read_im,
// status) appears for one cycle with done high; the receiver cannot stall.
// Steps from the accepting edge to the done cycle: clear and reset-qubit
// walk the vector in S_SWEEP, then S_FIN; write/read amplitude pass S_RWAIT,
// S_RDONE and S_FIN; matrix write and bad operands go straight to S_FIN.
// A gate scans every vector index in S_FIND. A single gate reads per pair
// 2 amplitudes via S_LOAD and S_LWAIT, then for each of 2 rows takes 2
// products in S_MAC and one writeback in S_WB. A double gate reads per group
// 4 amplitudes and runs 4 rows of 4 products each plus writeback. The vector
// memory has one port and the single complex MAC is shared by all products;
// together they set the rate.
// Reset: a clearing pass over all 2^QUBITS indices writes the reset vector
// (index zero near one, all else zero); busy stays high meanwhile and no
// result is reported. The matrix store is flops and clears at once.
// ----------------------------------------------------------------------------
module state_vector_gate_engine_top #(
	parameter int QUBITS   = 10,
	parameter int AMP_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic [4:0]         qubit_a,
	input  logic [4:0]         qubit_b,
	input  logic [19:0]        control_mask,
	input  logic               adjoint,
	input  logic [19:0]        slot,
	input  logic signed [15:0] value_re,
	input  logic signed [15:0] value_im,
	output logic               done,
	output logic signed [15:0] read_re,
	output logic signed [15:0] read_im,
	output logic [1:0]         status
);
	import svge_pkg::*;

	localparam int AB    = AMP_BITS;
	localparam int DEPTH = 1 << QUBITS;
	localparam int AW    = (QUBITS < 1) ? 1 : QUBITS;
	localparam int SW    = AB + 21;
	localparam logic signed [AB-1:0] AMAX = {1'b0, {(AB-1){1'b1}}};
	localparam logic signed [AB-1:0] AMIN = {1'b1, {(AB-1){1'b0}}};

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SWEEP  = 10'b0000000010,
		S_RWAIT  = 10'b0000000100,
		S_RDONE  = 10'b0000001000,
		S_FIND   = 10'b0000010000,
		S_LOAD   = 10'b0000100000,
		S_MAC    = 10'b0001000000,
		S_WB     = 10'b0010000000,
		S_FIN    = 10'b0100000000,
		S_LWAIT  = 10'b1000000000
	} state_t;

	state_t state_q;

	// latched request
	op_t              op_q;
	logic [AW-1:0]    sa_q, sb_q, mask_q;
	logic             adj_q, two_q;
	logic [AW-1:0]    idx_q;      // sweep / group base index
	logic [AW:0]      cnt_q;      // sweep / scan counter, MSB marks end of scan
	logic [1:0]       ld_q;       // load counter within a group
	logic [1:0]       row_q, col_q;
	logic             hit_q;
	logic             boot_q;     // high through the after-reset sweep
	logic signed [AB-1:0] ar_q [4];
	logic signed [AB-1:0] ai_q [4];
	logic signed [15:0] mre_q [16];
	logic signed [15:0] mim_q [16];

	// result regs
	logic             done_q;
	logic signed [15:0] rre_q, rim_q;
	logic [1:0]       st_q;

	// RAM port
	logic             we;
	logic [AW-1:0]    addr;
	logic [2*AB-1:0]  wdata, rdata;

	svge_ram #(.WIDTH(2*AB), .DEPTH(DEPTH)) u_amp (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// validation (combinational on request ports)
	logic qa_ok, qb_ok, mask_ok, slot_ok;
	logic [AW-1:0] sa_in, sb_in, mask_in;
	assign qa_ok   = 32'(qubit_a) < 32'(QUBITS);
	assign qb_ok   = 32'(qubit_b) < 32'(QUBITS);
	assign mask_ok = (64'(control_mask) >> QUBITS) == 64'd0;
	assign slot_ok = (64'(slot) >> QUBITS) == 64'd0;
	assign sa_in   = AW'(64'd1 << qubit_a);
	assign sb_in   = AW'(64'd1 << qubit_b);
	assign mask_in = AW'(control_mask);

	// group index of local position k: bit1 = qa, bit0 = qb (one-qubit gate: bit0 = qa)
	function automatic logic [AW-1:0] grp_idx(input logic [AW-1:0] base,
		input logic [1:0] k, input logic [AW-1:0] sa, input logic [AW-1:0] sb,
		input logic two);
		logic [AW-1:0] r;
		r = base;
		if (two) begin
			if (k[1]) r = r | sa;
			if (k[0]) r = r | sb;
		end else if (k[0]) begin
			r = r | sa;
		end
		return r;
	endfunction

	// conversions
	function automatic logic signed [AB-1:0] to_store(input logic signed [15:0] v);
		logic signed [47:0] w, rr;
		w = 48'(v);
		if (AB >= 16) begin
			return AB'(w <<< (AB - 16));
		end else begin
			rr = (w + (48'sd1 <<< (15 - AB))) >>> (16 - AB);
			if (rr > 48'(AMAX)) return AMAX;
			if (rr < 48'(AMIN)) return AMIN;
			return AB'(rr);
		end
	endfunction

	function automatic logic signed [15:0] from_store(input logic signed [AB-1:0] v);
		logic signed [47:0] w, rr;
		w = 48'(v);
		if (AB > 16) begin
			rr = (w + (48'sd1 <<< (AB - 17))) >>> (AB - 16);
			if (rr > 48'sd32767) return 16'sh7fff;
			return 16'(rr);
		end else begin
			return 16'(w <<< (16 - AB));
		end
	endfunction

	// MAC wiring
	mac_ctl_t         mctl;
	logic [3:0]       e_sel;
	logic signed [15:0] m_re;
	logic signed [16:0] m_im;
	logic signed [SW-1:0] s_re, s_im;
	logic [1:0]       nsz;

	assign nsz = two_q ? 2'd3 : 2'd1;
	always_comb begin
		if (two_q) e_sel = adj_q ? {col_q, row_q} : {row_q, col_q};
		else       e_sel = adj_q ? {1'b0, col_q[0], 1'b0, row_q[0]}
		                         : {1'b0, row_q[0], 1'b0, col_q[0]};
		// for 2x2: entry = r*2+c
		if (!two_q) e_sel = adj_q ? {2'b00, col_q[0], row_q[0]}
		                          : {2'b00, row_q[0], col_q[0]};
	end
	assign m_re = mre_q[e_sel];
	assign m_im = adj_q ? -17'(mim_q[e_sel]) : 17'(mim_q[e_sel]);
	assign mctl.clr = (state_q == S_LOAD) || (state_q == S_WB);
	assign mctl.acc = (state_q == S_MAC);

	svge_mac #(.AB(AB)) u_mac (
		.clk(clk), .ctl(mctl), .m_re(m_re), .m_im(m_im),
		.a_re(ar_q[col_q]), .a_im(ai_q[col_q]), .s_re(s_re), .s_im(s_im)
	);

	// round half up by 14 then saturate
	logic signed [SW-1:0] rnd_re, rnd_im;
	logic signed [AB-1:0] o_re, o_im;
	logic sat_re, sat_im;
	assign rnd_re = (s_re + SW'(1 <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
	assign rnd_im = (s_im + SW'(1 <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
	always_comb begin
		sat_re = 1'b0;
		sat_im = 1'b0;
		o_re   = AB'(rnd_re);
		o_im   = AB'(rnd_im);
		if (rnd_re > SW'(AMAX)) begin o_re = AMAX; sat_re = 1'b1; end
		if (rnd_re < SW'(AMIN)) begin o_re = AMIN; sat_re = 1'b1; end
		if (rnd_im > SW'(AMAX)) begin o_im = AMAX; sat_im = 1'b1; end
		if (rnd_im < SW'(AMIN)) begin o_im = AMIN; sat_im = 1'b1; end
	end

	// base index is valid for a gate when target bits are clear, mask bits set
	logic          base_ok;
	logic [AW-1:0] tmask;
	assign tmask   = two_q ? (sa_q | sb_q) : sa_q;
	assign base_ok = ((idx_q & tmask) == '0) && ((idx_q & mask_q) == mask_q);

	// memory port control
	always_comb begin
		we    = 1'b0;
		addr  = idx_q;
		wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				// amplitude write lands at the accepting edge
				if (start && op_t'(opcode) == OP_WRITE && slot_ok) begin
					we    = 1'b1;
					addr  = AW'(slot);
					wdata = {to_store(value_re), to_store(value_im)};
				end
			end
			S_SWEEP: begin
				addr = idx_q;
				if (op_q == OP_RESETQ) begin
					we = (idx_q & sa_q) != '0;
				end else begin
					we    = 1'b1;
					wdata = (idx_q == '0) ? {AMAX, {AB{1'b0}}} : '0;
				end
			end
			S_LOAD:  addr = grp_idx(idx_q, ld_q, sa_q, sb_q, two_q);
			S_WB: begin
				we    = 1'b1;
				addr  = grp_idx(idx_q, row_q, sa_q, sb_q, two_q);
				wdata = {o_re, o_im};
			end
			default: addr = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			op_q    <= OP_CLEAR;
			idx_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			st_q    <= ST_DONE;
			rre_q   <= '0;
			rim_q   <= '0;
			hit_q   <= 1'b0;
			ld_q    <= '0;
			row_q   <= '0;
			col_q   <= '0;
			sa_q    <= '0;
			sb_q    <= '0;
			mask_q  <= '0;
			adj_q   <= 1'b0;
			two_q   <= 1'b0;
			for (int k = 0; k < 16; k++) begin
				mre_q[k] <= '0;
				mim_q[k] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= op_t'(opcode);
						sa_q   <= sa_in;
						sb_q   <= sb_in;
						mask_q <= mask_in;
						adj_q  <= adjoint;
						two_q  <= (opcode == OP_GATE2);
						idx_q  <= '0;
						cnt_q  <= '0;
						hit_q  <= 1'b0;
						rre_q  <= '0;
						rim_q  <= '0;
						st_q   <= ST_DONE;
						state_q <= S_FIN;
						unique case (op_t'(opcode))
							OP_CLEAR: state_q <= S_SWEEP;
							OP_RESETQ: begin
								if (qa_ok) state_q <= S_SWEEP;
								else       st_q <= ST_BAD;
							end
							OP_WRITE, OP_READ: begin
								if (slot_ok) begin
									idx_q   <= AW'(slot);
									state_q <= S_RWAIT;
								end else begin
									st_q <= ST_BAD;
								end
							end
							OP_MATRIX: begin
								if (slot[19:4] == '0) begin
									mre_q[slot[3:0]] <= value_re;
									mim_q[slot[3:0]] <= value_im;
								end else begin
									st_q <= ST_BAD;
								end
							end
							OP_GATE1: begin
								if (qa_ok && mask_ok && (mask_in & sa_in) == '0)
									state_q <= S_FIND;
								else st_q <= ST_BAD;
							end
							OP_GATE2: begin
								if (qa_ok && qb_ok && qubit_a != qubit_b && mask_ok
								    && (mask_in & (sa_in | sb_in)) == '0)
									state_q <= S_FIND;
								else st_q <= ST_BAD;
							end
							default: st_q <= ST_BAD;
						endcase
					end
				end
				S_SWEEP: begin
					idx_q <= idx_q + AW'(1);
					cnt_q <= cnt_q + (AW+1)'(1);
					if (cnt_q == (AW+1)'(DEPTH - 1)) state_q <= S_FIN;
				end
				S_RWAIT: state_q <= S_RDONE;
				S_RDONE: begin
					if (op_q == OP_READ) begin
						rre_q <= from_store(rdata[2*AB-1:AB]);
						rim_q <= from_store(rdata[AB-1:0]);
					end
					state_q <= S_FIN;
				end
				S_FIND: begin
					// step through base indices; cnt_q MSB marks end of vector
					if (cnt_q[AW]) begin
						state_q <= S_FIN;
						if (hit_q) st_q <= ST_SAT;
					end else if (base_ok) begin
						ld_q    <= '0;
						state_q <= S_LOAD;
					end else begin
						idx_q <= idx_q + AW'(1);
						cnt_q <= cnt_q + (AW+1)'(1);
					end
				end
				S_LOAD: begin
					// address issued; data next cycle
					state_q <= S_LWAIT;
				end
				S_LWAIT: begin
					ar_q[ld_q] <= rdata[2*AB-1:AB];
					ai_q[ld_q] <= rdata[AB-1:0];
					if (ld_q == nsz) begin
						row_q   <= '0;
						col_q   <= '0;
						state_q <= S_MAC;
					end else begin
						ld_q    <= ld_q + 2'd1;
						state_q <= S_LOAD;
					end
				end
				S_MAC: begin
					if (col_q == nsz) state_q <= S_WB;
					else col_q <= col_q + 2'd1;
				end
				S_WB: begin
					hit_q <= hit_q | sat_re | sat_im;
					col_q <= '0;
					if (row_q == nsz) begin
						idx_q   <= idx_q + AW'(1);
						cnt_q   <= cnt_q + (AW+1)'(1);
						state_q <= S_FIND;
					end else begin
						row_q   <= row_q + 2'd1;
						state_q <= S_MAC;
					end
				end
				S_FIN: begin
					// reset sweep ends here without producing a result
					done_q  <= !boot_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// after-reset sweep must not report: track it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                       boot_q <= 1'b1;
		else if (state_q == S_FIN)         boot_q <= 1'b0;
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign read_re = rre_q;
	assign read_im = rim_q;
	assign status  = st_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIN)) else $error("done outside finish");
	a_we_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q == S_WB) |-> (op_q == OP_GATE1 || op_q == OP_GATE2))
		else $error("gate writeback on wrong opcode");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_sat_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_SAT) |-> (op_q == OP_GATE1 || op_q == OP_GATE2))
		else $error("saturation status on non-gate");
endmodule

/* tb/tb_state_vector_gate_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_state_vector_gate_engine_top
// Self-checking bench for the state vector gate engine: a directed pass over
// extremes, bad operands and saturation, then mostly well-formed random
// requests. An in-bench amplitude/matrix shadow predicts every result.
// ----------------------------------------------------------------------------
module tb_state_vector_gate_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import svge_pkg::*;

	localparam int NQ       = 10;
	localparam int VEC      = 1 << NQ;
	localparam int WATCHDOG = 40000;   // bound for the longest request plus gaps
	localparam int N_RANDOM = 555;

	typedef struct {
		op_t                op;
		logic [4:0]         qa;
		logic [4:0]         qb;
		logic [19:0]        mask;
		logic               adj;
		logic [19:0]        slot;
		logic signed [15:0] vre;
		logic signed [15:0] vim;
	} request_t;

	typedef struct {
		logic signed [15:0] rre;
		logic signed [15:0] rim;
		status_t            st;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         opcode = '0;
	logic [4:0]         qubit_a = '0;
	logic [4:0]         qubit_b = '0;
	logic [19:0]        control_mask = '0;
	logic               adjoint = 1'b0;
	logic [19:0]        slot = '0;
	logic signed [15:0] value_re = '0;
	logic signed [15:0] value_im = '0;
	logic               done;
	logic signed [15:0] read_re;
	logic signed [15:0] read_im;
	logic [1:0]         status;

	// shadow of the block's state (AMP_BITS = 16: store format is Q1.15)
	logic signed [15:0] vec_re [VEC];
	logic signed [15:0] vec_im [VEC];
	logic signed [15:0] mat_re [16];
	logic signed [15:0] mat_im [16];

	outcome_t pending_q[$];
	int       fail_cnt = 0;
	int       idle_cycles = 0;

	state_vector_gate_engine_top i_dut (
		.clk, .arst_n, .start, .busy, .opcode, .qubit_a, .qubit_b, .control_mask,
		.adjoint, .slot, .value_re, .value_im, .done, .read_re, .read_im, .status
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- model
	function automatic logic signed [15:0] sat16(longint x, ref bit hit);
		if (x > 32767) begin
			hit = 1'b1;
			return 16'sd32767;
		end
		if (x < -32768) begin
			hit = 1'b1;
			return -16'sd32768;
		end
		return x[15:0];
	endfunction

	function automatic void clear_vec();
		for (int i = 0; i < VEC; i++) begin
			vec_re[i] = '0;
			vec_im[i] = '0;
		end
		vec_re[0] = 16'sd32767;  // 1.0 is not representable
	endfunction

	// n x n matrix times the amplitudes at idx; products summed exactly, then
	// round half up at bit 14 and saturate
	function automatic void mix_block(int idx[4], int n, logic adj, ref bit hit);
		longint ar[4], ai[4], sr, si, mr, mi;
		int e;
		for (int r = 0; r < n; r++) begin
			ar[r] = vec_re[idx[r]];
			ai[r] = vec_im[idx[r]];
		end
		for (int r = 0; r < n; r++) begin
			sr = 0;
			si = 0;
			for (int c = 0; c < n; c++) begin
				e  = adj ? (c * n + r) : (r * n + c);
				mr = mat_re[e];
				mi = adj ? -longint'(mat_im[e]) : longint'(mat_im[e]);
				sr += mr * ar[c] - mi * ai[c];
				si += mr * ai[c] + mi * ar[c];
			end
			vec_re[idx[r]] = sat16((sr + 8192) >>> 14, hit);
			vec_im[idx[r]] = sat16((si + 8192) >>> 14, hit);
		end
	endfunction

	function automatic outcome_t predict_outcome(request_t q);
		outcome_t o;
		bit       hit;
		int       idx[4];
		int       sa, sb;
		o.rre = '0;
		o.rim = '0;
		o.st  = ST_DONE;
		hit   = 1'b0;
		case (q.op)
			OP_CLEAR: clear_vec();
			OP_WRITE: begin
				if (q.slot >= VEC) o.st = ST_BAD;
				else begin
					vec_re[q.slot] = q.vre;
					vec_im[q.slot] = q.vim;
				end
			end
			OP_READ: begin
				if (q.slot >= VEC) o.st = ST_BAD;
				else begin
					o.rre = vec_re[q.slot];
					o.rim = vec_im[q.slot];
				end
			end
			OP_MATRIX: begin
				if (q.slot >= 16) o.st = ST_BAD;
				else begin
					mat_re[q.slot] = q.vre;
					mat_im[q.slot] = q.vim;
				end
			end
			OP_GATE1: begin
				if (q.qa >= NQ || q.mask[19:NQ] != 0 || q.mask[q.qa]) o.st = ST_BAD;
				else begin
					sa = 1 << q.qa;
					for (int i = 0; i < VEC; i++) begin
						if ((i & sa) == 0 && (i & q.mask) == q.mask) begin
							idx[0] = i;
							idx[1] = i | sa;
							mix_block(idx, 2, q.adj, hit);
						end
					end
					if (hit) o.st = ST_SAT;
				end
			end
			OP_GATE2: begin
				if (q.qa >= NQ || q.qb >= NQ || q.qa == q.qb || q.mask[19:NQ] != 0 ||
						q.mask[q.qa] || q.mask[q.qb]) o.st = ST_BAD;
				else begin
					sa = 1 << q.qa;
					sb = 1 << q.qb;
					for (int i = 0; i < VEC; i++) begin
						if ((i & (sa | sb)) == 0 && (i & q.mask) == q.mask) begin
							idx[0] = i;
							idx[1] = i | sb;
							idx[2] = i | sa;
							idx[3] = i | sa | sb;
							mix_block(idx, 4, q.adj, hit);
						end
					end
					if (hit) o.st = ST_SAT;
				end
			end
			OP_RESETQ: begin
				// only qubit_a is checked; the mask plays no part
				if (q.qa >= NQ) o.st = ST_BAD;
				else begin
					for (int i = 0; i < VEC; i++) begin
						if (i[q.qa]) begin
							vec_re[i] = '0;
							vec_im[i] = '0;
						end
					end
				end
			end
			default: o.st = ST_BAD;
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------- driver
	// Fields go out at a rising edge; the request is taken at the first edge
	// that sees start high with busy low. A zero gap keeps start high into
	// the next request, so start never gets two assignments in one step.
	task automatic send_request(request_t q);
		int gap;
		opcode       <= q.op;
		qubit_a      <= q.qa;
		qubit_b      <= q.qb;
		control_mask <= q.mask;
		adjoint      <= q.adj;
		slot         <= q.slot;
		value_re     <= q.vre;
		value_im     <= q.vim;
		start        <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.insert(pending_q.size(), predict_outcome(q));
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic request_t mk(op_t op, int qa = 0, int qb = 0, int mask = 0,
			bit adj = 0, int sl = 0, int vre = 0, int vim = 0);
		request_t q;
		q.op   = op;
		q.qa   = 5'(qa);
		q.qb   = 5'(qb);
		q.mask = 20'(mask);
		q.adj  = adj;
		q.slot = 20'(sl);
		q.vre  = 16'(vre);
		q.vim  = 16'(vim);
		return q;
	endfunction

	// ---------------------------------------------------------------- checker
	// done is sampled before the edge's updates land, i.e. the value the
	// result cycle held.
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result re=%0d im=%0d status=%0d",
					$time, read_re, read_im, status);
				fail_cnt++;
			end else begin
				exp_o = pending_q.pop_front();
				if (read_re !== exp_o.rre) begin
					$display("%0t: read_re expected %0d actual %0d", $time, exp_o.rre, read_re);
					fail_cnt++;
				end
				if (read_im !== exp_o.rim) begin
					$display("%0t: read_im expected %0d actual %0d", $time, exp_o.rim, read_im);
					fail_cnt++;
				end
				if (status !== exp_o.st) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_o.st, status);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog: cycles with neither a request taken nor a result seen
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	// extremes of the fields, slot range checks, the unused opcode
	task automatic test_access();
		send_request(mk(OP_READ, .sl(0)));                       // reset vector
		send_request(mk(OP_WRITE, .sl(5), .vre(32767), .vim(-32768)));
		send_request(mk(OP_READ, .sl(5)));
		send_request(mk(OP_WRITE, .sl(VEC - 1), .vre(-1), .vim(1)));
		send_request(mk(OP_READ, .sl(VEC - 1)));
		send_request(mk(OP_WRITE, .sl(VEC), .vre(123), .vim(456)));  // out of range
		send_request(mk(OP_READ, .sl(20'hFFFFF)));
		send_request(mk(OP_MATRIX, .sl(16), .vre(1), .vim(1)));
		send_request(mk(OP_NONE, 31, 31, 20'hFFFFF, 1, 20'hFFFFF, -1, -1));
	endtask

	// Hadamard, adjoint and control, bad targets, saturation, qubit reset
	task automatic test_gates();
		send_request(mk(OP_MATRIX, .sl(0), .vre(11585)));
		send_request(mk(OP_MATRIX, .sl(1), .vre(11585)));
		send_request(mk(OP_MATRIX, .sl(2), .vre(11585)));
		send_request(mk(OP_MATRIX, .sl(3), .vre(-11585), .vim(-32768)));
		send_request(mk(OP_GATE1, .qa(0)));
		send_request(mk(OP_READ, .sl(1)));
		send_request(mk(OP_GATE1, .qa(0), .mask(2), .adj(1)));   // controlled, adjoint
		send_request(mk(OP_GATE1, .qa(NQ)));                     // target out of range
		send_request(mk(OP_GATE1, .qa(3), .mask(8)));            // target in mask
		send_request(mk(OP_GATE1, .qa(3), .mask(20'h80000)));    // mask above qubits
		send_request(mk(OP_GATE2, .qa(4), .qb(4)));              // equal targets
		send_request(mk(OP_GATE2, .qa(NQ - 1), .qb(0), .mask(6), .adj(1)));
		// adjoint turns the -2.0 imaginary entry into +2.0
		send_request(mk(OP_CLEAR));
		send_request(mk(OP_GATE1, .qa(2), .adj(1)));
		send_request(mk(OP_RESETQ, .qa(0), .mask(20'hFFFFF)));
		send_request(mk(OP_RESETQ, .qa(31)));
		send_request(mk(OP_CLEAR));
	endtask

	function automatic request_t random_request();
		request_t q;
		int       r;
		q.qa   = 5'($urandom_range(0, NQ - 1));
		q.qb   = 5'($urandom_range(0, NQ - 1));
		q.adj  = 1'($urandom_range(0, 1));
		q.mask = $urandom_range(0, 1) ? 20'h0 : 20'($urandom & $urandom & (VEC - 1));
		q.slot = 20'($urandom_range(0, VEC - 1));
		q.vre  = 16'($urandom);
		q.vim  = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 30) q.op = OP_WRITE;
		else if (r < 55) q.op = OP_READ;
		else if (r < 75) begin
			q.op   = OP_MATRIX;
			q.slot = 20'($urandom_range(0, 15));
			if ($urandom_range(0, 2) != 0) begin  // mostly tame entries
				q.vre = $signed(q.vre) >>> 2;
				q.vim = $signed(q.vim) >>> 2;
			end
		end else if (r < 85) begin
			q.op   = OP_GATE1;
			q.mask &= ~(20'h1 << q.qa);
		end else if (r < 90) begin
			q.op = OP_GATE2;
			if (q.qb == q.qa) q.qb = 5'((q.qa + 1) % NQ);
			q.mask &= ~((20'h1 << q.qa) | (20'h1 << q.qb));
		end else if (r < 93) q.op = OP_RESETQ;
		else if (r < 95) q.op = OP_CLEAR;
		else begin
			// noise: every field over its full width
			q.op   = op_t'($urandom_range(0, 7));
			q.qa   = 5'($urandom);
			q.qb   = 5'($urandom);
			q.mask = 20'($urandom);
			q.slot = 20'($urandom);
		end
		return q;
	endfunction

	task automatic test_random();
		for (int n = 0; n < N_RANDOM; n++) send_request(random_request());
	endtask

	initial begin
		int guard;
		clear_vec();
		for (int k = 0; k < 16; k++) begin
			mat_re[k] = '0;
			mat_im[k] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_access();
		test_gates();
		test_random();
		start <= 1'b0;

		// drain, then keep watching for any stray result
		guard = 0;
		while (pending_q.size() != 0 && guard < WATCHDOG) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (fail_cnt == 0 && pending_q.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
